[hw/rtl/srd_pkg.sv]
// Shared types, codes and constants of the separable RGBA downscaler.
// No dependencies; every other file of the block refers to it by scoped names.
package srd_pkg;

  // Default sizes, handed to the top level parameters
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int ACC_BITS_DEF  = 40;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_WIDTH = 1'b1;

  // Pixel modes
  localparam logic MODE_RGBA = 1'b0;
  localparam logic MODE_RGBX = 1'b1;

  // Byte conversion: 1.0 is 65025 * 16384, which fits 30 bits
  localparam int DEN_W = 30;
  localparam logic [DEN_W-1:0] UNIT_ONE = 30'd1065369600;
  localparam int NUM_W = DEN_W + 8;

  typedef enum logic [1:0] {
    OP_PIXEL     = 2'd0,
    OP_COL_END   = 2'd1,
    OP_ROW_START = 2'd2,
    OP_READ      = 2'd3
  } srd_op_t;

  typedef struct packed {
    srd_op_t            opcode;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic [7:0]         alpha_in;
    logic signed [15:0] weight0;
    logic signed [15:0] weight1;
    logic signed [15:0] weight2;
    logic signed [15:0] weight3;
  } srd_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       row_done;
  } srd_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_PIX_ACC,
    ST_FOLD_RD,
    ST_FOLD_MLO,
    ST_FOLD_MHI,
    ST_FOLD_WR,
    ST_SHIFT,
    ST_RD_RD,
    ST_RD_START,
    ST_RD_DIV,
    ST_RD_OUT
  } srd_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       item_load;
    logic       pix_prep;
    logic       pix_acc;
    logic       row_load;
    logic       fold_rd;
    logic       fold_mlo;
    logic       fold_mhi;
    logic       fold_wr;
    logic       fold_end;
    logic       rd_rd;
    logic       rd_start;
    logic       rd_take;
    logic       rd_out;
    logic       clr_wr;
    logic [1:0] lane;
    logic [1:0] tap;
    logic [1:0] chan;
  } srd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    srd_op_t op;
    logic    fold_ok;
    logic    div_busy;
    logic    clr_last;
    logic    out_free;
  } srd_stat_t;

endpackage

[hw/rtl/srd_div.sv]
// Byte conversion unit: floor((255*n + floor(d/2)) / d) for 0 <= n <= d.
// Restoring division, one quotient bit a cycle; depends on srd_pkg.
module srd_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [srd_pkg::DEN_W-1:0] num_n,
  input  logic [srd_pkg::DEN_W-1:0] den,
  output logic                      busy,
  output logic [7:0]                quot
);

  logic [srd_pkg::NUM_W-1:0] rem_r;
  logic [srd_pkg::NUM_W-2:0] dsh_r;
  logic [7:0]                quot_r;
  logic [2:0]                cnt_r;
  logic                      busy_r;
  logic [srd_pkg::NUM_W-1:0] n_ext;
  logic [srd_pkg::NUM_W-1:0] num_c;
  logic                      ge;

  // Scaled numerator with the rounding half-divisor
  assign n_ext = srd_pkg::NUM_W'(num_n);
  assign num_c = (n_ext << 8) - n_ext + srd_pkg::NUM_W'(den[srd_pkg::DEN_W-1:1]);
  assign ge    = rem_r >= {1'b0, dsh_r};

  // Control: eight steps after start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 3'd7;
    end else if (busy_r) begin
      if (cnt_r == 3'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 3'd1;
      end
    end
  end

  // Datapath: subtract the shifted divisor where it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num_c;
      dsh_r  <= {den, 7'b0};
      quot_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - {1'b0, dsh_r};
      end
      quot_r <= {quot_r[6:0], ge};
      dsh_r  <= dsh_r >> 1;
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule

[hw/rtl/srd_datapath.sv]
// Datapath: configuration, lane sums, vertical ring memory, fold multiplier,
// byte conversion and output register. Depends on srd_pkg and srd_div.
module srd_datapath #(
  parameter int MAX_WIDTH = srd_pkg::MAX_WIDTH_DEF,
  parameter int ACC_BITS  = srd_pkg::ACC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  srd_pkg::srd_cmd_t              cmd,
  output srd_pkg::srd_stat_t             st,
  input  srd_pkg::srd_in_t               in_data,
  input  logic                           cfg_wr_en,
  input  logic [srd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srd_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output srd_pkg::srd_out_t              out_data
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CNTW  = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH = 16 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int HW    = (ACC_BITS > 32) ? ACC_BITS - 32 : 1;
  localparam int PADW  = 32 + HW;
  localparam int FW    = PADW + 16;
  localparam int QW    = FW - 14;
  localparam int SW    = ACC_BITS + 2;
  localparam int DW    = srd_pkg::DEN_W;
  localparam logic [ACC_BITS-1:0] ACC_MAX_U = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  // Clamp a widened sum back into the accumulator range
  function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = ACC_MAX;
    lo = ACC_MIN;
    if (s > hi) begin
      return ACC_MAX;
    end else if (s < lo) begin
      return ACC_MIN;
    end
    return s[ACC_BITS-1:0];
  endfunction

  srd_pkg::srd_in_t              item_r;
  logic                          mode_r;
  logic [srd_pkg::CFG_DATA_W-1:0] owidth_r;
  logic [CNTW-1:0]               width_c;
  logic [CNTW-1:0]               in_col_r;
  logic [CW-1:0]                 out_col_r;
  logic [1:0]                    tap_r;
  logic signed [15:0]            vw_r [4];
  logic signed [ACC_BITS-1:0]    lane_r [4][4];
  logic [15:0]                   mlt_r [4];
  logic [PADW-1:0]               fmag_r;
  logic [15:0]                   faw_r;
  logic                          fneg_r;
  logic [47:0]                   pplo_r;
  logic [HW+15:0]                pphi_r;
  logic [DW-1:0]                 al_r;
  logic [7:0]                    byte_r [4];
  logic                          out_valid_r;
  srd_pkg::srd_out_t             out_data_r;
  logic [AW-1:0]                 clr_addr_r;
  logic [ACC_BITS-1:0]           ring_mem [DEPTH];
  logic [ACC_BITS-1:0]           rdata_r;

  logic [AW-1:0]                 mem_addr;
  logic                          mem_we;
  logic [ACC_BITS-1:0]           mem_wdata;
  logic                          fold_ok;
  logic [CW-1:0]                 rd_col;
  logic                          rd_last;
  logic signed [15:0]            w_sel;
  logic signed [ACC_BITS-1:0]    lsel;
  logic signed [15:0]            vsel;
  logic [1:0]                    slot;
  logic [FW-1:0]                 full;
  logic [FW-1:0]                 rnd;
  logic [QW-1:0]                 q;
  logic [ACC_BITS-1:0]           qc;
  logic signed [ACC_BITS-1:0]    fv;
  logic signed [ACC_BITS-1:0]    ring_s;
  logic signed [ACC_BITS-1:0]    ring_sum;
  logic [DW-1:0]                 div_d;
  logic [DW-1:0]                 div_n;
  logic                          div_busy;
  logic [7:0]                    div_q;
  logic [7:0]                    px_a [4];
  logic [7:0]                    px_b [4];

  // Effective width: zero counts as one, clip to the ring size
  always_comb begin
    if (owidth_r == '0) begin
      width_c = CNTW'(1);
    end else if (32'(owidth_r) > MAX_WIDTH) begin
      width_c = CNTW'(MAX_WIDTH);
    end else begin
      width_c = CNTW'(owidth_r);
    end
  end

  assign fold_ok = in_col_r < width_c;

  // Read column and end of row
  always_comb begin
    if (CNTW'(out_col_r) < width_c) begin
      rd_col = out_col_r;
    end else begin
      rd_col = CW'(width_c - CNTW'(1));
    end
    rd_last = (CNTW'(rd_col) + CNTW'(1)) >= width_c;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= srd_pkg::MODE_RGBA;
      owidth_r <= srd_pkg::CFG_DATA_W'(1);
    end else if (cfg_wr_en) begin
      if (cfg_index == srd_pkg::CFG_PIXEL_MODE) begin
        mode_r <= cfg_data[0];
      end else if (cfg_index == srd_pkg::CFG_OUTPUT_WIDTH) begin
        owidth_r <= cfg_data;
      end
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_r <= in_data;
    end
  end

  // Pixel factors per channel, before the weight multiply
  always_comb begin
    if (mode_r == srd_pkg::MODE_RGBA) begin
      px_a[0] = item_r.alpha_in; px_b[0] = item_r.red_in;
      px_a[1] = item_r.alpha_in; px_b[1] = item_r.green_in;
      px_a[2] = item_r.alpha_in; px_b[2] = item_r.blue_in;
      px_a[3] = item_r.alpha_in; px_b[3] = 8'hFF;
    end else begin
      px_a[0] = 8'hFF; px_b[0] = item_r.red_in;
      px_a[1] = 8'hFF; px_b[1] = item_r.green_in;
      px_a[2] = 8'hFF; px_b[2] = item_r.blue_in;
      px_a[3] = 8'hFF; px_b[3] = 8'hFF;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_prep) begin
      for (int c = 0; c < 4; c++) begin
        mlt_r[c] <= 16'(px_a[c]) * 16'(px_b[c]);
      end
    end
  end

  // Horizontal weight of the lane in turn
  always_comb begin
    case (cmd.lane)
      2'd0:    w_sel = item_r.weight0;
      2'd1:    w_sel = item_r.weight1;
      2'd2:    w_sel = item_r.weight2;
      default: w_sel = item_r.weight3;
    endcase
  end

  // Lane sums: cleared on row start, rotate through lane 0 on pixels, shift on column end
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.row_load) begin
      for (int k = 0; k < 4; k++) begin
        for (int c = 0; c < 4; c++) begin
          lane_r[k][c] <= '0;
        end
      end
    end else if (cmd.pix_acc) begin
      for (int c = 0; c < 4; c++) begin
        lane_r[0][c] <= lane_r[1][c];
        lane_r[1][c] <= lane_r[2][c];
        lane_r[2][c] <= lane_r[3][c];
        lane_r[3][c] <= sat_acc(SW'(lane_r[0][c]) +
                                SW'(w_sel) * SW'($signed({1'b0, mlt_r[c]})));
      end
    end else if (cmd.fold_end) begin
      for (int c = 0; c < 4; c++) begin
        lane_r[0][c] <= lane_r[1][c];
        lane_r[1][c] <= lane_r[2][c];
        lane_r[2][c] <= lane_r[3][c];
        lane_r[3][c] <= '0;
      end
    end
  end

  // Vertical weights and input column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < 4; t++) begin
        vw_r[t] <= '0;
      end
      in_col_r <= '0;
    end else if (cmd.row_load) begin
      vw_r[0]  <= item_r.weight0;
      vw_r[1]  <= item_r.weight1;
      vw_r[2]  <= item_r.weight2;
      vw_r[3]  <= item_r.weight3;
      in_col_r <= '0;
    end else if (cmd.fold_end && fold_ok) begin
      in_col_r <= in_col_r + CNTW'(1);
    end
  end

  // Fold: sign and magnitude, then two partial products
  assign lsel = lane_r[0][cmd.chan];
  assign vsel = vw_r[cmd.tap];

  always_ff @(posedge clk) begin
    if (cmd.fold_rd) begin
      fneg_r <= lsel[ACC_BITS-1] ^ vsel[15];
      fmag_r <= PADW'(lsel[ACC_BITS-1] ? ACC_BITS'(-lsel) : ACC_BITS'(lsel));
      faw_r  <= vsel[15] ? 16'(-vsel) : 16'(vsel);
    end
    if (cmd.fold_mlo) begin
      pplo_r <= 48'(fmag_r[31:0]) * 48'(faw_r);
    end
    if (cmd.fold_mhi) begin
      pphi_r <= (HW+16)'(fmag_r[PADW-1:32]) * (HW+16)'(faw_r);
    end
  end

  // Round half away from zero, clip, then add into the ring entry
  always_comb begin
    full     = {pphi_r, 32'b0} + FW'(pplo_r);
    rnd      = (full + FW'(8192)) >> 14;
    q        = rnd[QW-1:0];
    qc       = (q > QW'(ACC_MAX_U)) ? ACC_MAX_U : q[ACC_BITS-1:0];
    fv       = fneg_r ? -$signed(qc) : $signed(qc);
    ring_s   = $signed(rdata_r);
    ring_sum = sat_acc(SW'(ring_s) + SW'(fv));
  end

  // Ring memory: one address for read and write of each entry
  assign slot = tap_r + cmd.tap;

  always_comb begin
    if (cmd.clr_wr) begin
      mem_addr = clr_addr_r;
    end else if (cmd.fold_rd || cmd.fold_mlo || cmd.fold_mhi || cmd.fold_wr) begin
      mem_addr = AW'({in_col_r[CW-1:0], slot, cmd.chan});
    end else begin
      mem_addr = AW'({rd_col, tap_r, cmd.chan});
    end
  end

  assign mem_we    = cmd.clr_wr || cmd.fold_wr || cmd.rd_start;
  assign mem_wdata = cmd.fold_wr ? ring_sum : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= ring_mem[mem_addr];
  end

  // Clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // Byte conversion operands: alpha first, then the colours
  always_comb begin
    if (cmd.chan == 2'd3) begin
      div_d = srd_pkg::UNIT_ONE;
    end else if (mode_r == srd_pkg::MODE_RGBA && al_r != '0) begin
      div_d = al_r;
    end else begin
      div_d = srd_pkg::UNIT_ONE;
    end
    if (ring_s[ACC_BITS-1]) begin
      div_n = '0;
    end else if (ring_s > $signed(ACC_BITS'(div_d))) begin
      div_n = div_d;
    end else begin
      div_n = ring_s[DW-1:0];
    end
  end

  srd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.rd_start),
    .num_n (div_n),
    .den   (div_d),
    .busy  (div_busy),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd_start && cmd.chan == 2'd3) begin
      al_r <= div_n;
    end
    if (cmd.rd_take) begin
      byte_r[cmd.chan] <= div_q;
    end
  end

  // Output register and column bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_col_r   <= '0;
      tap_r       <= '0;
    end else if (cmd.rd_out) begin
      out_valid_r <= 1'b1;
      if (rd_last) begin
        out_col_r <= '0;
        tap_r     <= tap_r + 2'd1;
      end else begin
        out_col_r <= rd_col + CW'(1);
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_out) begin
      out_data_r.red_out   <= byte_r[0];
      out_data_r.green_out <= byte_r[1];
      out_data_r.blue_out  <= byte_r[2];
      out_data_r.alpha_out <= (mode_r == srd_pkg::MODE_RGBX) ? 8'hFF : byte_r[3];
      out_data_r.row_done  <= rd_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status to the controller
  assign st.op       = item_r.opcode;
  assign st.fold_ok  = fold_ok;
  assign st.div_busy = div_busy;
  assign st.clr_last = clr_addr_r == AW'(DEPTH - 1);
  assign st.out_free = !out_valid_r || out_ready;

endmodule

[hw/rtl/srd_ctrl.sv]
// Controller: sequences the steps of each request and the clearing sweep.
// Depends on srd_pkg for the state, command and status types.
module srd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output srd_pkg::srd_cmd_t  cmd,
  input  srd_pkg::srd_stat_t st
);

  srd_pkg::srd_state_t state_r;
  srd_pkg::srd_state_t state_nxt;
  logic [3:0]          cnt_r;
  logic [3:0]          cnt_nxt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srd_pkg::ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.lane  = cnt_r[1:0];
    cmd.tap   = cnt_r[3:2];
    cmd.chan  = cnt_r[1:0];
    unique case (state_r)
      srd_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) begin
          state_nxt = srd_pkg::ST_IDLE;
        end
      end
      srd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = srd_pkg::ST_DECODE;
        end
      end
      srd_pkg::ST_DECODE: begin
        unique case (st.op)
          srd_pkg::OP_PIXEL: begin
            cmd.pix_prep = 1'b1;
            state_nxt    = srd_pkg::ST_PIX_ACC;
          end
          srd_pkg::OP_COL_END: begin
            state_nxt = st.fold_ok ? srd_pkg::ST_FOLD_RD : srd_pkg::ST_SHIFT;
          end
          srd_pkg::OP_ROW_START: begin
            cmd.row_load = 1'b1;
            state_nxt    = srd_pkg::ST_IDLE;
          end
          default: begin
            state_nxt = srd_pkg::ST_RD_RD;
          end
        endcase
      end
      srd_pkg::ST_PIX_ACC: begin
        cmd.pix_acc = 1'b1;
        cnt_nxt     = cnt_r + 4'd1;
        if (cnt_r[1:0] == 2'd3) begin
          state_nxt = srd_pkg::ST_IDLE;
        end
      end
      srd_pkg::ST_FOLD_RD: begin
        cmd.fold_rd = 1'b1;
        state_nxt   = srd_pkg::ST_FOLD_MLO;
      end
      srd_pkg::ST_FOLD_MLO: begin
        cmd.fold_mlo = 1'b1;
        state_nxt    = srd_pkg::ST_FOLD_MHI;
      end
      srd_pkg::ST_FOLD_MHI: begin
        cmd.fold_mhi = 1'b1;
        state_nxt    = srd_pkg::ST_FOLD_WR;
      end
      srd_pkg::ST_FOLD_WR: begin
        cmd.fold_wr = 1'b1;
        cnt_nxt     = cnt_r + 4'd1;
        state_nxt   = (cnt_r == 4'd15) ? srd_pkg::ST_SHIFT : srd_pkg::ST_FOLD_RD;
      end
      srd_pkg::ST_SHIFT: begin
        cmd.fold_end = 1'b1;
        state_nxt    = srd_pkg::ST_IDLE;
      end
      // Read: alpha first, then red, green, blue
      srd_pkg::ST_RD_RD: begin
        cmd.chan  = cnt_r[1:0] + 2'd3;
        cmd.rd_rd = 1'b1;
        state_nxt = srd_pkg::ST_RD_START;
      end
      srd_pkg::ST_RD_START: begin
        cmd.chan     = cnt_r[1:0] + 2'd3;
        cmd.rd_start = 1'b1;
        state_nxt    = srd_pkg::ST_RD_DIV;
      end
      srd_pkg::ST_RD_DIV: begin
        cmd.chan = cnt_r[1:0] + 2'd3;
        if (!st.div_busy) begin
          cmd.rd_take = 1'b1;
          cnt_nxt     = cnt_r + 4'd1;
          state_nxt   = (cnt_r[1:0] == 2'd3) ? srd_pkg::ST_RD_OUT : srd_pkg::ST_RD_RD;
        end
      end
      srd_pkg::ST_RD_OUT: begin
        if (st.out_free) begin
          cmd.rd_out = 1'b1;
          state_nxt  = srd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = srd_pkg::ST_IDLE;
      end
    endcase
  end

  // A pending result is never overwritten
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_out |-> st.out_free)
    else $error("result loaded over a pending one");

  // No request is taken during the clearing sweep
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !in_ready)
    else $error("request taken while clearing");

  // A ring write follows both partial products
  a_fold_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fold_wr |-> $past(cmd.fold_mhi) && $past(cmd.fold_mlo, 2))
    else $error("fold write without products");

  // Each start command sets the divider busy
  a_div_take: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_start |=> st.div_busy)
    else $error("divider did not start");

endmodule

[hw/rtl/separable_rgba_downscaler.sv]
// Top level of the separable four-tap RGBA downscaler.
// Joins srd_ctrl and srd_datapath; types and defaults come from srd_pkg.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | srd_in_t (opcode, RGBA bytes, four weights)
//  out_    | output    | out_valid/out_ready| srd_out_t (RGBA bytes, row_done)
//  cfg_    | input     | cfg_wr_en          | cfg_index, cfg_data
//
// One request at a time. A pixel makes four lane updates through one shared set of
// multipliers; a column end folds 16 ring entries, each read, multiplied in two halves
// by the split 32x16 multiplier and written back, and skips the fold past the row width;
// a read makes four bit-serial byte conversions of 8 steps each. After reset all
// 16*MAX_WIDTH ring entries are swept to zero, with in_ready low. The output register
// frees in_ready from out_ready; a read waits at its end only while an earlier result
// is still pending.
module separable_rgba_downscaler #(
  parameter int MAX_WIDTH = srd_pkg::MAX_WIDTH_DEF,
  parameter int ACC_BITS  = srd_pkg::ACC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  srd_pkg::srd_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output srd_pkg::srd_out_t              out_data,
  input  logic                           cfg_wr_en,
  input  logic [srd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srd_pkg::CFG_DATA_W-1:0] cfg_data
);

  srd_pkg::srd_cmd_t  cmd;
  srd_pkg::srd_stat_t st;

  srd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st)
  );

  srd_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .ACC_BITS  (ACC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
